### hdl/nfc_tag_id_reply_sequencer_unit_macros.svh
// Assertion macros shared by the tag-ID reply sequencer RTL.
`ifndef NFC_TAG_ID_REPLY_SEQUENCER_UNIT_MACROS_SVH
`define NFC_TAG_ID_REPLY_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define NFCTAG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define NFCTAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/nfctag_pkg.sv
// Types, constants and byte tables for the tag-ID reply sequencer.
package nfctag_pkg;

  localparam int DUMP_BYTES = 64;
  localparam int DUMP_AW    = $clog2(DUMP_BYTES);
  localparam int IDX_W      = DUMP_AW + 1;

  localparam int FB_W     = 5;
  localparam int TAG_W    = 5;
  localparam logic [TAG_W-1:0] TAG_HEAD_LEN = TAG_W'(5);
  localparam logic [TAG_W-1:0] TAG_LAST     = TAG_W'(17);

  localparam logic [7:0] BYTE_FF     = 8'hFF;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_LEN_TAG = 8'h0F;
  localparam logic [7:0] BYTE_STATUS = 8'h41;
  localparam logic [7:0] CHAR_EQ     = 8'h3D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [FB_W-1:0] FRAME_BYTES_RST = FB_W'(16);
  localparam logic REG_FRAME_BYTES = 1'b0;

  typedef enum logic [3:0] {
    PH_SETUP  = 4'd0,
    PH_RETRY  = 4'd1,
    PH_ACK    = 4'd2,
    PH_HEADER = 4'd3,
    PH_TAG    = 4'd4,
    PH_WAIT41 = 4'd5,
    PH_STATUS = 4'd6,
    PH_GRAB   = 4'd7,
    PH_DONE   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIN
  } ctl_state_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

  // ACK frame; its first three bytes double as the reply header
  function automatic logic [7:0] ack_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd2, 3'd4: b = BYTE_FF;
      default:    b = BYTE_ZERO;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] tag_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'hF1;
      3'd1:    b = 8'hD5;
      3'd2:    b = 8'h4B;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

### hdl/nfc_tag_id_reply_sequencer_unit.sv
// Top level of the tag-ID reply sequencer.
//
// Input channel (in_valid/in_stall, opcode, rx_byte): each word is a start
// event (opcode 1) or one byte received from the reader (opcode 0).
// Output channel (out_valid/out_stall): exactly one result word per input
// word, in order: phase, command, read_page and the status flags.
// Config: APB register 0 (byte address 0) holds frame_bytes, reset 16.
// An ordinary word is captured in the item register on accept; its result
// is loaded from the EXEC state once the output register is free.
// The byte that closes the fourth page read also runs the dump scan, which
// streams the 64-entry dump through the byte classifier one entry per cycle.
// One word at a time: in_stall is high from accept until the result is
// loaded. A word may be accepted while the previous result still waits in
// the output register; if out_stall holds that result, the new word waits
// for the register to free before its result is loaded.
// Reset: phase setup, all counters cleared, dump empty, output empty,
// frame_bytes back to 16. A start event empties the dump through its fill
// count, so no clearing pass is needed.
`include "nfc_tag_id_reply_sequencer_unit_macros.svh"

module nfc_tag_id_reply_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  phase,
  output logic [1:0]  command,
  output logic [3:0]  read_page,
  output logic        retry_flag,
  output logic        ack_fail_flag,
  output logic        success_flag,
  output logic        reply_seen
);

  nfctag_pkg::ctl_state_t state, state_next;

  logic [nfctag_pkg::FB_W-1:0] frame_bytes;

  logic       item_op;
  logic [7:0] item_byte;

  nfctag_pkg::phase_t main_phase, main_phase_next;
  logic [2:0]                   ack_step, ack_step_next;
  logic [1:0]                   header_step, header_step_next;
  logic [nfctag_pkg::TAG_W-1:0] tag_step, tag_step_next;
  logic [1:0]                   frame_number, frame_number_next;
  logic [nfctag_pkg::FB_W-1:0]  frame_count, frame_count_next;
  logic [nfctag_pkg::IDX_W-1:0] widx, widx_next;
  logic                         seen, seen_next;
  logic                         found;

  logic [1:0] res_cmd;
  logic [3:0] res_page;
  logic       res_retry;
  logic       res_ackf;
  logic       res_succ;
  logic       need_scan;
  logic       dump_we;

  logic in_accept;
  logic out_free;
  logic exec_go;
  logic fin_go;
  logic out_load;
  logic ram_we;

  logic [nfctag_pkg::DUMP_AW-1:0] rd_addr;
  logic [7:0]                     rd_data;
  nfctag_pkg::scan_stat_t         scan_stat;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == nfctag_pkg::REG_FRAME_BYTES) ?
                  {{(32 - nfctag_pkg::FB_W){1'b0}}, frame_bytes} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes <= nfctag_pkg::FRAME_BYTES_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == nfctag_pkg::REG_FRAME_BYTES) begin
      frame_bytes <= pwdata[nfctag_pkg::FB_W-1:0];
    end
  end

  // control FSM
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      nfctag_pkg::ST_IDLE: if (in_accept) state_next = nfctag_pkg::ST_EXEC;
      nfctag_pkg::ST_EXEC: begin
        if (out_free) begin
          state_next = need_scan ? nfctag_pkg::ST_SCAN : nfctag_pkg::ST_IDLE;
        end
      end
      nfctag_pkg::ST_SCAN: if (scan_stat.done) state_next = nfctag_pkg::ST_FIN;
      nfctag_pkg::ST_FIN:  if (out_free) state_next = nfctag_pkg::ST_IDLE;
      default: state_next = nfctag_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    exec_go  = 1'b0;
    fin_go   = 1'b0;
    unique case (state)
      nfctag_pkg::ST_IDLE: in_stall = 1'b0;
      nfctag_pkg::ST_EXEC: exec_go = out_free;
      nfctag_pkg::ST_SCAN: ;
      nfctag_pkg::ST_FIN:  fin_go = out_free;
      default: ;
    endcase
  end

  assign out_load = (exec_go && !need_scan) || fin_go;
  assign ram_we   = exec_go && dump_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfctag_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_op   <= opcode;
      item_byte <= rx_byte;
    end
  end

  // per-word protocol step
  always_comb begin
    main_phase_next   = main_phase;
    ack_step_next     = ack_step;
    header_step_next  = header_step;
    tag_step_next     = tag_step;
    frame_number_next = frame_number;
    frame_count_next  = frame_count;
    widx_next         = widx;
    seen_next         = seen;
    res_cmd           = nfctag_pkg::CMD_NONE;
    res_page          = '0;
    res_retry         = 1'b0;
    res_ackf          = 1'b0;
    res_succ          = 1'b0;
    need_scan         = 1'b0;
    dump_we           = 1'b0;
    if (state == nfctag_pkg::ST_FIN) begin
      main_phase_next = found ? nfctag_pkg::PH_DONE : nfctag_pkg::PH_RETRY;
      res_succ        = found;
      res_retry       = !found;
    end else if (item_op) begin
      main_phase_next   = nfctag_pkg::PH_ACK;
      ack_step_next     = '0;
      header_step_next  = '0;
      tag_step_next     = '0;
      frame_number_next = '0;
      frame_count_next  = '0;
      widx_next         = '0;
      res_cmd           = nfctag_pkg::CMD_SEARCH;
    end else begin
      unique case (main_phase)
        nfctag_pkg::PH_SETUP: begin
          if (item_byte == nfctag_pkg::BYTE_FF) seen_next = 1'b1;
        end
        nfctag_pkg::PH_ACK: begin
          if (item_byte == nfctag_pkg::ack_byte(ack_step)) begin
            ack_step_next = ack_step + 1'b1;
            if (ack_step == 3'd5) main_phase_next = nfctag_pkg::PH_HEADER;
          end else begin
            main_phase_next = nfctag_pkg::PH_RETRY;
            res_retry       = 1'b1;
            res_ackf        = 1'b1;
          end
        end
        nfctag_pkg::PH_HEADER: begin
          if (header_step != 2'd3) begin
            if (item_byte == nfctag_pkg::ack_byte({1'b0, header_step})) begin
              header_step_next = header_step + 1'b1;
            end else begin
              main_phase_next = nfctag_pkg::PH_RETRY;
              res_retry       = 1'b1;
            end
          end else if (item_byte == nfctag_pkg::BYTE_LEN_TAG) begin
            main_phase_next = nfctag_pkg::PH_TAG;
          end else begin
            main_phase_next = nfctag_pkg::PH_RETRY;
            res_retry       = 1'b1;
          end
        end
        nfctag_pkg::PH_TAG: begin
          if ((tag_step < nfctag_pkg::TAG_HEAD_LEN) ?
              (item_byte != nfctag_pkg::tag_byte(tag_step[2:0])) :
              (item_byte == nfctag_pkg::BYTE_FF)) begin
            main_phase_next = nfctag_pkg::PH_RETRY;
            res_retry       = 1'b1;
          end else begin
            tag_step_next = tag_step + 1'b1;
            if (tag_step == nfctag_pkg::TAG_LAST) begin
              frame_number_next = '0;
              frame_count_next  = '0;
              main_phase_next   = nfctag_pkg::PH_WAIT41;
              res_cmd           = nfctag_pkg::CMD_READ;
            end
          end
        end
        nfctag_pkg::PH_WAIT41: begin
          if (item_byte == nfctag_pkg::BYTE_STATUS) main_phase_next = nfctag_pkg::PH_STATUS;
        end
        nfctag_pkg::PH_STATUS: begin
          if (item_byte == nfctag_pkg::BYTE_ZERO) main_phase_next = nfctag_pkg::PH_GRAB;
        end
        nfctag_pkg::PH_GRAB: begin
          if (frame_count < frame_bytes) begin
            if (widx < nfctag_pkg::IDX_W'(nfctag_pkg::DUMP_BYTES)) begin
              dump_we   = 1'b1;
              widx_next = widx + 1'b1;
            end
            frame_count_next = frame_count + 1'b1;
          end else begin
            frame_count_next = '0;
            if (frame_number != 2'd3) begin
              frame_number_next = frame_number + 1'b1;
              main_phase_next   = nfctag_pkg::PH_WAIT41;
              res_cmd           = nfctag_pkg::CMD_READ;
              res_page          = {frame_number + 2'd1, 2'b00};
            end else begin
              need_scan = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_phase   <= nfctag_pkg::PH_SETUP;
      ack_step     <= '0;
      header_step  <= '0;
      tag_step     <= '0;
      frame_number <= '0;
      frame_count  <= '0;
      widx         <= '0;
      seen         <= 1'b0;
      found        <= 1'b0;
    end else begin
      if (exec_go || fin_go) begin
        main_phase   <= main_phase_next;
        ack_step     <= ack_step_next;
        header_step  <= header_step_next;
        tag_step     <= tag_step_next;
        frame_number <= frame_number_next;
        frame_count  <= frame_count_next;
        widx         <= widx_next;
        seen         <= seen_next;
      end
      if (scan_stat.done) begin
        found <= scan_stat.found;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      phase         <= main_phase_next;
      command       <= res_cmd;
      read_page     <= res_page;
      retry_flag    <= res_retry;
      ack_fail_flag <= res_ackf;
      success_flag  <= res_succ;
      reply_seen    <= seen_next;
    end
  end

  nfctag_ram #(
    .WIDTH (8),
    .DEPTH (nfctag_pkg::DUMP_BYTES)
  ) u_dump (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx[nfctag_pkg::DUMP_AW-1:0]),
    .wdata (item_byte),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  nfctag_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (exec_go && need_scan),
    .fill    (widx),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .stat    (scan_stat)
  );

  `NFCTAG_ASSERT_NOW(a_scan_done_in_scan, scan_stat.done,
    state == nfctag_pkg::ST_SCAN, "scan finished outside scan state")
  `NFCTAG_ASSERT_NOW(a_dump_write_grab, ram_we,
    main_phase == nfctag_pkg::PH_GRAB &&
    widx < nfctag_pkg::IDX_W'(nfctag_pkg::DUMP_BYTES), "dump write outside grab or past end")
  `NFCTAG_ASSERT_NOW(a_no_result_overwrite, out_load,
    !(out_valid && out_stall), "result loaded over a stalled result")
  `NFCTAG_ASSERT_NEXT(a_accept_to_exec, in_accept,
    state == nfctag_pkg::ST_EXEC, "accepted word not taken into execution")

endmodule

### hdl/nfctag_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nfctag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/nfctag_scan.sv
// Dump scanner: streams the dump through one byte classifier looking for '=' and four digits.
module nfctag_scan (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [nfctag_pkg::IDX_W-1:0]   fill,
  output logic [nfctag_pkg::DUMP_AW-1:0] rd_addr,
  input  logic [7:0]                     rd_data,
  output nfctag_pkg::scan_stat_t         stat
);

  logic                           busy;
  logic [nfctag_pkg::IDX_W-1:0]   ptr;
  logic                           chk_valid;
  logic [nfctag_pkg::DUMP_AW-1:0] chk_addr;
  logic                           digit_mode;
  logic [1:0]                     dcnt;

  logic       issue;
  logic [7:0] cur;
  logic       hit;
  logic       ptr_end;

  assign ptr_end = (ptr == nfctag_pkg::IDX_W'(nfctag_pkg::DUMP_BYTES));
  assign issue   = busy && !ptr_end;
  assign rd_addr = ptr[nfctag_pkg::DUMP_AW-1:0];

  // entries at or past the fill count were never written since start: zero
  assign cur = ({1'b0, chk_addr} < fill) ? rd_data : 8'h00;

  // shared classifier
  always_comb begin
    if (digit_mode) begin
      hit = (cur >= nfctag_pkg::CHAR_ZERO) && (cur <= nfctag_pkg::CHAR_NINE);
    end else begin
      hit = (cur == nfctag_pkg::CHAR_EQ);
    end
  end

  always_comb begin
    stat = '0;
    if (busy) begin
      if (digit_mode) begin
        if (chk_valid) begin
          stat.done  = !hit || (dcnt == 2'd3);
          stat.found = hit && (dcnt == 2'd3);
        end
      end else if (chk_valid) begin
        stat.done = hit &&
          (chk_addr >= nfctag_pkg::DUMP_AW'(nfctag_pkg::DUMP_BYTES - 4));
      end else begin
        stat.done = ptr_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      ptr        <= '0;
      chk_valid  <= 1'b0;
      chk_addr   <= '0;
      digit_mode <= 1'b0;
      dcnt       <= '0;
    end else if (start) begin
      busy       <= 1'b1;
      ptr        <= '0;
      chk_valid  <= 1'b0;
      digit_mode <= 1'b0;
      dcnt       <= '0;
    end else if (busy) begin
      if (stat.done) begin
        busy <= 1'b0;
      end
      chk_valid <= issue;
      chk_addr  <= ptr[nfctag_pkg::DUMP_AW-1:0];
      if (issue) begin
        ptr <= ptr + 1'b1;
      end
      if (chk_valid) begin
        if (digit_mode) begin
          dcnt <= dcnt + 1'b1;
        end else if (hit) begin
          digit_mode <= 1'b1;
          dcnt       <= '0;
        end
      end
    end
  end

endmodule
